// ===== sv/brbpd_pkg.sv =====
// shared types and constants for the byte ring buffer with peek and drop
// no dependencies
`default_nettype none

package brbpd_pkg;

	// default sizing, used as the defaults of the top level parameters
	localparam int CAPACITY_DEF = 4096;
	localparam int MAX_READ_DEF = 64;

	// item field widths
	localparam int FUNC_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 7;
	localparam int DROP_W  = 13;
	localparam int STAT_W  = 2;
	localparam int LEVEL_W = 13;

	// stream packing
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE = 3'd0,
		FUNC_READ  = 3'd1,
		FUNC_PEEK  = 3'd2,
		FUNC_DROP  = 3'd3,
		FUNC_RESET = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_BURST = 1'b1
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;      // request accepted this cycle
		logic burst_on;  // byte burst in progress
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;   // output register can load this cycle
		logic burst_req;  // current request is a read or peek that emits bytes
		logic burst_done; // last byte of the burst moved to the output register
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/brbpd_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module brbpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/brbpd_ctrl.sv =====
// controller state machine: idle request intake and byte bursts
// depends on brbpd_pkg
`default_nettype none

module brbpd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire brbpd_pkg::sts_t   sts,
	output brbpd_pkg::cmd_t        cmd
);

	brbpd_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brbpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.take     = 1'b0;
		cmd.burst_on = 1'b0;
		unique case (state_q)
			brbpd_pkg::ST_IDLE: begin
				s_tready = sts.out_free;
				cmd.take = s_tvalid && sts.out_free;
				if (cmd.take && sts.burst_req) begin
					state_d = brbpd_pkg::ST_BURST;
				end
			end
			brbpd_pkg::ST_BURST: begin
				cmd.burst_on = 1'b1;
				if (sts.burst_done) begin
					state_d = brbpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = brbpd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/brbpd_dp.sv =====
// datapath: head and fill registers, byte ram, burst address counter, output register
// depends on brbpd_pkg and brbpd_ram
`default_nettype none

module brbpd_dp #(
	parameter int CAPACITY = brbpd_pkg::CAPACITY_DEF,
	parameter int MAX_READ = brbpd_pkg::MAX_READ_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire brbpd_pkg::cmd_t                 cmd,
	output brbpd_pkg::sts_t                      sts,
	input  wire logic [brbpd_pkg::FUNC_W-1:0]    func,
	input  wire logic [brbpd_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic [brbpd_pkg::LEN_W-1:0]     read_length,
	input  wire logic [brbpd_pkg::DROP_W-1:0]    drop_count,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [brbpd_pkg::BYTE_W-1:0]    out_byte,
	output logic      [brbpd_pkg::STAT_W-1:0]    status,
	output logic                                 last,
	output logic      [brbpd_pkg::LEVEL_W-1:0]   level
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int FW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (FW > brbpd_pkg::DROP_W) ? FW : brbpd_pkg::DROP_W;
	localparam int SW   = CMPW + 1;
	localparam int LW   = brbpd_pkg::LEN_W;

	logic [AW-1:0] head_q, head_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [AW-1:0] raddr_q;
	logic [LW-1:0] remain_q;
	logic          pend_q, pend_last_q;

	logic [brbpd_pkg::BYTE_W-1:0] ram_rdata;

	brbpd_pkg::func_t fn;
	logic [LW-1:0]    rlen;
	logic [CMPW-1:0]  fill_c, rlen_c, dcnt_c, amt_c;
	logic [SW-1:0]    sum, sum_w;
	logic [AW-1:0]    adv;
	logic             full, enough, is_rdpk;
	logic             wr_en, single_load, out_can, ram_take, issue;
	brbpd_pkg::stat_t stat_single;

	assign fn     = brbpd_pkg::func_t'(func);
	assign rlen   = (read_length > LW'(MAX_READ)) ? LW'(MAX_READ) : read_length;
	assign fill_c = CMPW'(fill_q);
	assign rlen_c = CMPW'(rlen);
	assign dcnt_c = CMPW'(drop_count);
	assign full   = (fill_q == FW'(CAPACITY));
	assign enough = (fill_c >= rlen_c);
	assign is_rdpk = (fn == brbpd_pkg::FUNC_READ) || (fn == brbpd_pkg::FUNC_PEEK);

	// one shared wrapping adder: tail for writes, advance for reads and drops
	assign amt_c = (fn == brbpd_pkg::FUNC_WRITE) ? fill_c :
	               (is_rdpk ? rlen_c : dcnt_c);
	assign sum   = SW'(head_q) + SW'(amt_c);
	assign sum_w = (sum >= SW'(CAPACITY)) ? (sum - SW'(CAPACITY)) : sum;
	assign adv   = AW'(sum_w);

	always_comb begin
		head_d      = head_q;
		fill_d      = fill_q;
		wr_en       = 1'b0;
		stat_single = brbpd_pkg::STAT_OK;
		unique case (fn)
			brbpd_pkg::FUNC_WRITE: begin
				if (full) begin
					stat_single = brbpd_pkg::STAT_FULL;
				end else begin
					wr_en  = 1'b1;
					fill_d = fill_q + FW'(1);
				end
			end
			brbpd_pkg::FUNC_READ: begin
				if (!enough) begin
					stat_single = brbpd_pkg::STAT_SHORT;
				end else begin
					head_d = adv;
					fill_d = fill_q - FW'(rlen_c);
				end
			end
			brbpd_pkg::FUNC_PEEK: begin
				if (!enough) begin
					stat_single = brbpd_pkg::STAT_SHORT;
				end
			end
			brbpd_pkg::FUNC_DROP: begin
				if (fill_c <= dcnt_c) begin
					head_d = '0;
					fill_d = '0;
				end else begin
					head_d = adv;
					fill_d = fill_q - FW'(dcnt_c);
				end
			end
			brbpd_pkg::FUNC_RESET: begin
				head_d = '0;
				fill_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign sts.burst_req = is_rdpk && (rlen != '0) && enough;

	// output register loads when empty or being drained this cycle
	assign out_can        = !out_valid || out_ready;
	assign sts.out_free   = out_can;
	assign single_load    = cmd.take && !sts.burst_req;
	assign ram_take       = cmd.burst_on && pend_q && out_can;
	assign issue          = cmd.burst_on && (remain_q != '0) && (!pend_q || ram_take);
	assign sts.burst_done = ram_take && pend_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fill_q      <= '0;
			remain_q    <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cmd.take) begin
				head_q <= head_d;
				fill_q <= fill_d;
			end
			if (cmd.take && sts.burst_req) begin
				remain_q <= rlen;
			end else if (issue) begin
				remain_q <= remain_q - LW'(1);
			end
			if (issue) begin
				pend_q      <= 1'b1;
				pend_last_q <= (remain_q == LW'(1));
			end else if (ram_take) begin
				pend_q <= 1'b0;
			end
			if (single_load || ram_take) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// burst read address, wraps at the end of the store
	always_ff @(posedge clk) begin
		if (cmd.take && sts.burst_req) begin
			raddr_q <= head_q;
		end else if (issue) begin
			raddr_q <= (raddr_q == AW'(CAPACITY - 1)) ? '0 : raddr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (single_load) begin
			out_byte <= '0;
			status   <= stat_single;
			last     <= 1'b1;
			level    <= brbpd_pkg::LEVEL_W'(CMPW'(fill_d));
		end else if (ram_take) begin
			out_byte <= ram_rdata;
			status   <= brbpd_pkg::STAT_OK;
			last     <= pend_last_q;
			level    <= brbpd_pkg::LEVEL_W'(fill_c);
		end
	end

	brbpd_ram #(
		.WIDTH (brbpd_pkg::BYTE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (cmd.take && wr_en),
		.waddr (adv),
		.wdata (data_byte),
		.re    (issue),
		.raddr (raddr_q),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// ===== sv/byte_ring_buffer_peek_drop.sv =====
// Byte ring buffer with read, peek and drop. The store holds CAPACITY bytes as
// a ring (head pointer plus fill count) in one ram with a single write port and
// a registered read port. Each request enters on the slave stream with its
// function code in s_tuser: write appends one byte (refused with status full
// when the store is full), read and peek return read_length bytes (capped at
// MAX_READ) oldest first with tlast on the final byte, drop discards bytes from
// the head, reset empties the store. Every result carries the fill level after
// its request. Write, drop, reset, unknown codes, zero-length and short reads
// and peeks give exactly one result. A read or peek of N bytes is accepted,
// then its bytes are read from the ram one per cycle through the registered
// read port while the output side keeps up, each byte reaching the output
// register after its ram read. No new request is taken during such a burst.
// The store needs no clearing after reset.
// depends on brbpd_pkg, brbpd_ctrl, brbpd_dp
`default_nettype none

module byte_ring_buffer_peek_drop #(
	parameter int CAPACITY = brbpd_pkg::CAPACITY_DEF,
	parameter int MAX_READ = brbpd_pkg::MAX_READ_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// data_byte[7:0], read_length[14:8], drop_count[27:15], zero pad [31:28]
	input  wire logic [brbpd_pkg::S_TDATA_W-1:0]     s_tdata,
	// func[2:0]
	input  wire logic [brbpd_pkg::FUNC_W-1:0]        s_tuser,
	// result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// out_byte[7:0], level[20:8], zero pad [23:21]
	output logic      [brbpd_pkg::M_TDATA_W-1:0]     m_tdata,
	// status[1:0]
	output logic      [brbpd_pkg::STAT_W-1:0]        m_tuser,
	output logic                                     m_tlast
);

	localparam int RL_LO = brbpd_pkg::BYTE_W;
	localparam int DC_LO = RL_LO + brbpd_pkg::LEN_W;
	localparam int LV_LO = brbpd_pkg::BYTE_W;

	brbpd_pkg::cmd_t cmd;
	brbpd_pkg::sts_t sts;

	logic [brbpd_pkg::BYTE_W-1:0]  out_byte;
	logic [brbpd_pkg::LEVEL_W-1:0] level;

	// controller: accepts requests while idle, holds off intake during bursts
	brbpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: pointers, ram, burst counter and output register
	brbpd_dp #(
		.CAPACITY (CAPACITY),
		.MAX_READ (MAX_READ)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (s_tuser),
		.data_byte   (s_tdata[brbpd_pkg::BYTE_W-1:0]),
		.read_length (s_tdata[DC_LO-1:RL_LO]),
		.drop_count  (s_tdata[DC_LO+brbpd_pkg::DROP_W-1:DC_LO]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (out_byte),
		.status      (m_tuser),
		.last        (m_tlast),
		.level       (level)
	);

	// pack result fields, byte in the low bits, level above, zero pad on top
	assign m_tdata = {{(brbpd_pkg::M_TDATA_W - LV_LO - brbpd_pkg::LEVEL_W){1'b0}},
	                  level, out_byte};

`ifndef NO_ASSERTIONS
	// the controller leaves the burst once the final byte is handed over
	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		sts.burst_done |=> !cmd.burst_on)
		else $error("burst did not end after its last byte");

	// no request may be taken while a burst is running
	a_no_take_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.burst_on |-> !cmd.take)
		else $error("request taken during a burst");

	// a failed request gives a single, final result
	a_fail_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != brbpd_pkg::STAT_OK)) |-> m_tlast)
		else $error("error result not marked last");

	// bytes only come with an ok status
	a_byte_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[brbpd_pkg::BYTE_W-1:0] != '0)) |->
		(m_tuser == brbpd_pkg::STAT_OK))
		else $error("data byte on an error result");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for byte_ring_buffer_peek_drop: directed, drain and random requests
// keeps its own copy of the ring and checks every result; depends on brbpd_pkg and the rtl
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY   = brbpd_pkg::CAPACITY_DEF;
	localparam int MAX_READ   = brbpd_pkg::MAX_READ_DEF;
	localparam int CYCLE_CAP  = 2_000_000;  // far above the slowest legal run
	localparam int TAIL_WAIT  = 16;         // cycles watched for stray results at the end
	localparam int MAX_SHOWN  = 10;

	// function codes the block has no meaning for
	localparam logic [brbpd_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
	localparam logic [brbpd_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

	typedef struct {
		logic [brbpd_pkg::BYTE_W-1:0]  out_byte;
		brbpd_pkg::stat_t              status;
		logic                          last;
		logic [brbpd_pkg::LEVEL_W-1:0] level;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [brbpd_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [brbpd_pkg::FUNC_W-1:0]    s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [brbpd_pkg::M_TDATA_W-1:0] m_tdata;
	logic [brbpd_pkg::STAT_W-1:0]    m_tuser;
	logic                            m_tlast;

	// shadow copy of the ring
	logic [brbpd_pkg::BYTE_W-1:0] ring_bytes [0:CAPACITY-1];
	int                           ring_head = 0;
	int                           ring_fill = 0;

	result_t expected_results [$];

	int  mismatches = 0;
	int  cycles = 0;
	bit  quiet = 1'b0;      // no idling on either side once set
	bit  src_calm = 1'b0;   // sender idles not at all for a while
	bit  sink_calm = 1'b0;  // receiver never stalls for a while
	int  sink_hold = 0;

	byte_ring_buffer_peek_drop #(
		.CAPACITY(CAPACITY),
		.MAX_READ(MAX_READ)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	// cycle count, run limit, and slow changes of the idling mood
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 64 == 0) begin
			src_calm  <= ($urandom_range(0, 2) == 0);
			sink_calm <= ($urandom_range(0, 2) == 0);
		end
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_results.size());
			$display("** byte_ring_buffer_peek_drop: FAILED **");
			$finish;
		end
	end

	// result side backpressure in bursts, started only when neither quiet nor calm
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else if (!quiet && !sink_calm && $urandom_range(0, 5) == 0) begin
			sink_hold <= $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each accepted result against the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("cycle %0d: unexpected result byte %02h status %0d last %0d level %0d",
						cycles, m_tdata[7:0], m_tuser, m_tlast, m_tdata[20:8]);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[7:0] !== want.out_byte || m_tuser !== want.status ||
						m_tlast !== want.last || m_tdata[20:8] !== want.level) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display({"cycle %0d: expected byte %02h status %0d last %0d level %0d,",
							" got byte %02h status %0d last %0d level %0d"}, cycles,
							want.out_byte, want.status, want.last, want.level,
							m_tdata[7:0], m_tuser, m_tlast, m_tdata[20:8]);
				end
			end
		end
	end

	// update the shadow ring for one accepted request and queue what it should return
	function automatic void apply_request(logic [brbpd_pkg::FUNC_W-1:0] code,
			logic [brbpd_pkg::BYTE_W-1:0] data, logic [brbpd_pkg::LEN_W-1:0] len,
			logic [brbpd_pkg::DROP_W-1:0] drop);
		result_t                      r;
		logic [brbpd_pkg::BYTE_W-1:0] got [MAX_READ];
		int                           n;
		r.out_byte = '0;
		r.status = brbpd_pkg::STAT_OK;
		r.last = 1'b1;
		case (code)
			brbpd_pkg::FUNC_WRITE: begin
				if (ring_fill >= CAPACITY) begin
					r.status = brbpd_pkg::STAT_FULL;
				end else begin
					ring_bytes[(ring_head + ring_fill) % CAPACITY] = data;
					ring_fill++;
				end
			end
			brbpd_pkg::FUNC_READ, brbpd_pkg::FUNC_PEEK: begin
				n = (len > MAX_READ) ? MAX_READ : int'(len);  // long requests are capped
				if (ring_fill < n) begin
					r.status = brbpd_pkg::STAT_SHORT;
				end else if (n > 0) begin
					for (int i = 0; i < n; i++)
						got[i] = ring_bytes[(ring_head + i) % CAPACITY];
					if (code == brbpd_pkg::FUNC_READ) begin
						// head stays where it lands, even when the ring empties
						ring_head = (ring_head + n) % CAPACITY;
						ring_fill -= n;
					end
					for (int i = 0; i < n; i++) begin
						r.out_byte = got[i];
						r.last = (i == n - 1);
						r.level = ring_fill[brbpd_pkg::LEVEL_W-1:0];
						expected_results.push_back(r);
					end
					return;
				end
			end
			brbpd_pkg::FUNC_DROP: begin
				if (ring_fill <= drop) begin
					ring_fill = 0;
					ring_head = 0;
				end else begin
					ring_head = (ring_head + drop) % CAPACITY;
					ring_fill -= drop;
				end
			end
			brbpd_pkg::FUNC_RESET: begin
				ring_fill = 0;
				ring_head = 0;
			end
			default: ;  // spare codes are answered with a plain ok
		endcase
		r.level = ring_fill[brbpd_pkg::LEVEL_W-1:0];
		expected_results.push_back(r);
	endfunction

	// offer one request, maybe after a random idle gap, and wait for its handshake
	// valid is left high afterwards so back-to-back requests need no second assignment
	task automatic send_request(logic [brbpd_pkg::FUNC_W-1:0] code,
			logic [brbpd_pkg::BYTE_W-1:0] data, logic [brbpd_pkg::LEN_W-1:0] len,
			logic [brbpd_pkg::DROP_W-1:0] drop);
		if (!quiet && !src_calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= code;
		s_tdata <= {{(brbpd_pkg::S_TDATA_W - brbpd_pkg::BYTE_W - brbpd_pkg::LEN_W -
			brbpd_pkg::DROP_W){1'b0}}, drop, len, data};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_request(code, data, len, drop);
	endtask

	// stop sending and wait until every queued result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// empty ring corner cases, every function, spare codes, field extremes
	task automatic test_basic_ops();
		send_request(brbpd_pkg::FUNC_READ, 8'h3c, 7'd0, 13'd0);     // zero length on empty ring
		send_request(brbpd_pkg::FUNC_PEEK, 8'hc3, 7'd1, 13'd0);     // short request
		send_request(brbpd_pkg::FUNC_DROP, 8'h00, 7'd0, 13'd0);     // zero drop on empty ring
		send_request(brbpd_pkg::FUNC_WRITE, 8'h00, 7'd0, 13'd0);
		send_request(brbpd_pkg::FUNC_WRITE, 8'hff, 7'd127, 13'd8191);
		send_request(brbpd_pkg::FUNC_WRITE, 8'ha5, 7'd0, 13'd0);
		send_request(brbpd_pkg::FUNC_WRITE, 8'h5a, 7'd0, 13'd0);
		send_request(brbpd_pkg::FUNC_PEEK, 8'h00, 7'd4, 13'd0);
		send_request(brbpd_pkg::FUNC_READ, 8'h00, 7'd127, 13'd0);   // capped to 64, still short
		send_request(brbpd_pkg::FUNC_PEEK, 8'h00, 7'd0, 13'd0);     // zero length on a non-empty ring
		send_request(brbpd_pkg::FUNC_READ, 8'h00, 7'd2, 13'd0);
		send_request(brbpd_pkg::FUNC_DROP, 8'h00, 7'd0, 13'd0);     // zero drop keeps the bytes
		for (int c = int'(FUNC_SPARE_LO); c <= int'(FUNC_SPARE_HI); c++)
			send_request(brbpd_pkg::FUNC_W'(c), 8'hff, 7'd127, 13'd8191);
		send_request(brbpd_pkg::FUNC_WRITE, 8'h81, 7'd0, 13'd0);
		send_request(brbpd_pkg::FUNC_DROP, 8'h00, 7'd0, 13'd1);     // partial drop moves the head
		send_request(brbpd_pkg::FUNC_PEEK, 8'h00, 7'd2, 13'd0);
		send_request(brbpd_pkg::FUNC_RESET, 8'hff, 7'd127, 13'd8191);
		send_request(brbpd_pkg::FUNC_READ, 8'h00, 7'd1, 13'd0);
		send_request(brbpd_pkg::FUNC_WRITE, 8'h7e, 7'd0, 13'd0);
		send_request(brbpd_pkg::FUNC_DROP, 8'h00, 7'd0, 13'd4096);  // drop of at least the fill
		send_request(brbpd_pkg::FUNC_DROP, 8'h00, 7'd64, 13'd8191);
	endtask

	// fill part of the ring, peek it whole, drain the results, then read it out
	task automatic test_fill_and_drain();
		send_request(brbpd_pkg::FUNC_RESET, 8'h00, 7'd0, 13'd0);
		for (int i = 0; i < 40; i++)
			send_request(brbpd_pkg::FUNC_WRITE, 8'($urandom), 7'd0, 13'd0);
		send_request(brbpd_pkg::FUNC_PEEK, 8'h00, 7'd64, 13'd0);    // short by 24
		send_request(brbpd_pkg::FUNC_PEEK, 8'h00, 7'd40, 13'd0);    // whole ring
		// let everything come back before carrying on
		wait_drained();
		send_request(brbpd_pkg::FUNC_READ, 8'h00, 7'd100, 13'd0);   // capped to 64, short
		send_request(brbpd_pkg::FUNC_READ, 8'h00, 7'd17, 13'd0);
		send_request(brbpd_pkg::FUNC_READ, 8'h00, 7'(ring_fill), 13'd0);  // empties, head stays
		send_request(brbpd_pkg::FUNC_WRITE, 8'h99, 7'd0, 13'd0);
		send_request(brbpd_pkg::FUNC_PEEK, 8'h00, 7'd1, 13'd0);
	endtask

	// mostly writes and reads the ring can serve, with some drops, resets, short, oversized and spare requests
	task automatic test_random_traffic(int count, int calm_tail);
		int                           pick;
		int                           room;
		logic [brbpd_pkg::FUNC_W-1:0] code;
		logic [brbpd_pkg::LEN_W-1:0]  len;
		logic [brbpd_pkg::DROP_W-1:0] drop;
		for (int k = 0; k < count; k++) begin
			if (k == count - calm_tail)
				quiet <= 1'b1;
			pick = $urandom_range(0, 99);
			len = 7'($urandom);
			drop = 13'($urandom);
			if (pick < 45) begin
				code = brbpd_pkg::FUNC_WRITE;
			end else if (pick < 80) begin
				code = (pick < 65) ? brbpd_pkg::FUNC_READ : brbpd_pkg::FUNC_PEEK;
				room = (ring_fill < MAX_READ) ? ring_fill : MAX_READ;
				if ($urandom_range(0, 9) < 8)
					len = 7'($urandom_range(0, room));
			end else if (pick < 92) begin
				code = brbpd_pkg::FUNC_DROP;
				if ($urandom_range(0, 4) != 0)
					drop = 13'($urandom_range(0, ring_fill / 2 + 1));
			end else if (pick < 95) begin
				code = brbpd_pkg::FUNC_RESET;
			end else begin
				code = brbpd_pkg::FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
			end
			send_request(code, 8'($urandom), len, drop);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_fill_and_drain();
		test_random_traffic(60, 30);
		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("** byte_ring_buffer_peek_drop: PASSED **");
		else
			$display("** byte_ring_buffer_peek_drop: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
